>>> design/fbo_pkg.sv
`default_nettype none
package fbo_pkg;

   typedef enum logic [2:0] {
      CMD_NEGATE       = 3'd0,
      CMD_ABSOLUTE     = 3'd1,
      CMD_TWICE        = 3'd2,
      CMD_HALF         = 3'd3,
      CMD_FLOAT_TO_INT = 3'd4,
      CMD_INT_TO_FLOAT = 3'd5
   } cmd_type;

   localparam int unsigned CMD_W  = 3;
   localparam int unsigned WORD_W = 32;
   localparam int unsigned EXP_W  = 8;
   localparam int unsigned FRAC_W = 23;

   localparam logic [WORD_W-1:0] SIGN_BIT = 32'h8000_0000;
   localparam logic [WORD_W-1:0] MAG_MASK = 32'h7fff_ffff;
   localparam logic [EXP_W-1:0]  EXP_MAX  = 8'hff;
   localparam logic [EXP_W-1:0]  EXP_BIAS = 8'h7f;
   // exponent at or above which a float no longer fits a signed 32-bit integer
   localparam logic [EXP_W-1:0]  F2I_OVF_EXP = 8'd158;

   function automatic logic is_nan(input logic [WORD_W-1:0] f);
      return (f[30:23] == EXP_MAX) && (f[22:0] != '0);
   endfunction

endpackage
`default_nettype wire

>>> design/float32_bit_ops_unit_top.sv
// A transfer accepted by the block is registered in the input register, and its result is
//   loaded into the result register (rsp_valid high after it) once that register is free.
// Throughput: one transfer per cycle while req_stall is low; the input and result registers
//   each hold one item, so req_stall rises only when both are full and rsp_stall is high.
// Reset (synchronous, active high) clears both valid flags; payload registers are not reset.
`default_nettype none
module float32_bit_ops_unit_top (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [fbo_pkg::CMD_W-1:0]   req_cmd,
   input  wire logic [fbo_pkg::WORD_W-1:0]  req_operand,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic      [fbo_pkg::WORD_W-1:0]  rsp_result
);
   import fbo_pkg::*;

   // input register stage
   logic              s1_valid_ff;
   logic              s1_valid_in;
   logic [CMD_W-1:0]  s1_cmd_ff;
   logic [WORD_W-1:0] s1_operand_ff;

   // result register stage
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [WORD_W-1:0] rsp_result_ff;
   logic [WORD_W-1:0] rsp_result_in;

   logic req_take;   // input transfer this cycle
   logic out_move;   // result register can take a new value
   logic s1_load;    // input register can take a new value

   // Result register frees up when empty or when its transfer completes.
   assign out_move  = !rsp_valid_ff || !rsp_stall;
   // Input register frees up when empty or when its item moves to the result register.
   assign s1_load   = !s1_valid_ff || out_move;
   assign req_stall = !s1_load;
   assign req_take  = req_valid && s1_load;

   assign s1_valid_in  = s1_load ? req_valid : s1_valid_ff;
   assign rsp_valid_in = out_move ? s1_valid_ff : rsp_valid_ff;

   // all the arithmetic sits between the two registers
   fbo_exec u_exec (
      .cmd     (s1_cmd_ff),
      .operand (s1_operand_ff),
      .result  (rsp_result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_cmd_ff     <= req_cmd;
         s1_operand_ff <= req_operand;
      end
      if (out_move && s1_valid_ff) begin
         rsp_result_ff <= rsp_result_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;

   // backpressure only when the input stage actually holds an item
   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid_ff))
      else $error("req_stall with a free input stage");

   // an accepted transfer lands in the input stage
   a_take_lands: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> s1_valid_ff)
      else $error("accepted transfer lost");

   // an item leaving the input stage shows up as a result
   a_item_moves: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && out_move) |=> rsp_valid_ff)
      else $error("item dropped between stages");

   // a blocked input stage keeps its item
   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_move) |=> (s1_valid_ff && $stable(s1_operand_ff)
                                      && $stable(s1_cmd_ff)))
      else $error("input stage changed while blocked");

endmodule
`default_nettype wire

>>> design/fbo_f2i.sv
`default_nettype none
module fbo_f2i (
   input  wire logic [fbo_pkg::WORD_W-1:0] operand,
   output logic      [fbo_pkg::WORD_W-1:0] result
);
   import fbo_pkg::*;

   logic [EXP_W-1:0]  exp_f;
   logic [EXP_W-1:0]  exp_off;
   logic [4:0]        sh;
   logic [54:0]       wide;
   logic [WORD_W-1:0] mag;

   always_comb begin
      exp_f   = operand[30:23];
      exp_off = exp_f - EXP_BIAS;
      sh      = exp_off[4:0];
      wide    = {31'd0, 1'b1, operand[22:0]} << sh;
      mag     = wide[54:23];
      if (is_nan(operand) || (exp_f < EXP_BIAS)) begin
         result = '0;
      end else if (exp_f >= F2I_OVF_EXP) begin
         result = SIGN_BIT;
      end else if (operand[31]) begin
         result = '0 - mag;
      end else begin
         result = mag;
      end
   end

endmodule
`default_nettype wire

>>> design/fbo_i2f.sv
`default_nettype none
module fbo_i2f (
   input  wire logic [fbo_pkg::WORD_W-1:0] operand,
   output logic      [fbo_pkg::WORD_W-1:0] result
);
   import fbo_pkg::*;

   logic              sgn;
   logic [WORD_W-1:0] mag;
   logic [4:0]        msb;
   logic [WORD_W-1:0] norm;
   logic [23:0]       keep;
   logic              guard;
   logic              sticky;
   logic              round_up;
   logic [24:0]       rounded;
   logic [EXP_W-1:0]  exp_r;

   always_comb begin
      sgn = operand[31];
      mag = sgn ? ('0 - operand) : operand;
      msb = '0;
      for (int i = 0; i < WORD_W; i++) begin
         if (mag[i]) begin
            msb = 5'(i);
         end
      end
      // leading one to bit 31; bits below the kept 24 feed rounding
      norm     = mag << (5'd31 - msb);
      keep     = norm[31:8];
      guard    = norm[7];
      sticky   = |norm[6:0];
      round_up = guard && (sticky || keep[0]);
      rounded  = {1'b0, keep} + {24'd0, round_up};
      exp_r    = {3'd0, msb} + EXP_BIAS + {7'd0, rounded[24]};
      if (mag == '0) begin
         result = '0;
      end else if (rounded[24]) begin
         result = {sgn, exp_r, rounded[23:1]};
      end else begin
         result = {sgn, exp_r, rounded[22:0]};
      end
   end

endmodule
`default_nettype wire

>>> design/fbo_exec.sv
`default_nettype none
module fbo_exec (
   input  wire logic [fbo_pkg::CMD_W-1:0]  cmd,
   input  wire logic [fbo_pkg::WORD_W-1:0] operand,
   output logic      [fbo_pkg::WORD_W-1:0] result
);
   import fbo_pkg::*;

   logic [WORD_W-1:0] f2i_result;
   logic [WORD_W-1:0] i2f_result;
   logic [WORD_W-1:0] twice_r;
   logic [WORD_W-1:0] half_r;
   logic [EXP_W-1:0]  exp_f;
   logic              nan;
   logic              half_up;
   logic [30:0]       half_mag;

   fbo_f2i u_f2i (
      .operand (operand),
      .result  (f2i_result)
   );

   fbo_i2f u_i2f (
      .operand (operand),
      .result  (i2f_result)
   );

   always_comb begin
      exp_f = operand[30:23];
      nan   = is_nan(operand);

      // twice: subnormal shifts into the exponent, top finite exponent overflows
      if (exp_f == EXP_MAX) begin
         twice_r = operand;
      end else if (exp_f == '0) begin
         twice_r = {operand[31], 7'd0, operand[22:0], 1'b0};
      end else if (exp_f == EXP_MAX - 8'd1) begin
         twice_r = {operand[31], EXP_MAX, 23'd0};
      end else begin
         twice_r = {operand[31], exp_f + 8'd1, operand[22:0]};
      end

      // half: near zero the magnitude shifts right with round to nearest even
      half_up  = (operand[1:0] == 2'b11);
      half_mag = {1'b0, operand[30:1]} + {30'd0, half_up};
      if (exp_f == EXP_MAX) begin
         half_r = operand;
      end else if (exp_f <= 8'd1) begin
         half_r = {operand[31], half_mag};
      end else begin
         half_r = {operand[31], exp_f - 8'd1, operand[22:0]};
      end

      unique case (cmd_type'(cmd))
         CMD_NEGATE:       result = nan ? operand : (operand ^ SIGN_BIT);
         CMD_ABSOLUTE:     result = nan ? operand : (operand & MAG_MASK);
         CMD_TWICE:        result = nan ? operand : twice_r;
         CMD_HALF:         result = nan ? operand : half_r;
         CMD_FLOAT_TO_INT: result = f2i_result;
         CMD_INT_TO_FLOAT: result = i2f_result;
         default:          result = '0;
      endcase
   end

endmodule
`default_nettype wire

>>> sim/float32_bit_ops_unit_top_test.sv
`timescale 1ns / 1ps
`default_nettype none
module float32_bit_ops_unit_top_test;
   import fbo_pkg::*;

   // Codes that the block does not define; both must give a zero result.
   localparam logic [CMD_W-1:0] CMD_UNUSED_6 = 3'd6;
   localparam logic [CMD_W-1:0] CMD_UNUSED_7 = 3'd7;

   localparam int RANDOM_PER_PHASE = 375;
   localparam int N_PHASES         = 4;
   localparam int DRAIN_CYCLES     = 10;
   // The limit lies far beyond the slowest legal run.
   localparam int CYCLE_LIMIT      = 200000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [CMD_W-1:0]  req_cmd = '0;
   logic [WORD_W-1:0] req_operand = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [WORD_W-1:0] rsp_result;

   float32_bit_ops_unit_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_cmd     (req_cmd),
      .req_operand (req_operand),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_result  (rsp_result)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // One row of the directed table. Where has_word is set, word is the result
   // read straight off the definition; otherwise the predictor supplies it.
   typedef struct packed {
      logic [CMD_W-1:0]  op;
      logic [WORD_W-1:0] operand;
      logic              has_word;
      logic [WORD_W-1:0] word;
   } stim_row_type;

   typedef struct packed {
      logic [CMD_W-1:0]  op;
      logic [WORD_W-1:0] operand;
      logic [WORD_W-1:0] word;
   } pending_word_type;

   localparam int N_DIRECTED = 25;
   stim_row_type directed_rows [0:N_DIRECTED-1] = '{
      // sign flips, NaN passes through
      '{CMD_NEGATE,       32'h0000_0000, 1'b1, 32'h8000_0000},
      '{CMD_NEGATE,       32'h7fc0_0001, 1'b1, 32'h7fc0_0001},
      '{CMD_ABSOLUTE,     32'hff80_0000, 1'b1, 32'h7f80_0000},
      '{CMD_ABSOLUTE,     32'hffff_ffff, 1'b1, 32'hffff_ffff},
      // twice: infinity kept, overflow to infinity, subnormal carry into exponent
      '{CMD_TWICE,        32'h7f80_0000, 1'b1, 32'h7f80_0000},
      '{CMD_TWICE,        32'h7f7f_ffff, 1'b1, 32'h7f80_0000},
      '{CMD_TWICE,        32'h0040_0000, 1'b1, 32'h0080_0000},
      '{CMD_TWICE,        32'h807f_ffff, 1'b0, 32'h0},
      // half: infinity kept, rounding near zero, plain exponent decrement
      '{CMD_HALF,         32'hff80_0000, 1'b1, 32'hff80_0000},
      '{CMD_HALF,         32'h0000_0003, 1'b1, 32'h0000_0002},
      '{CMD_HALF,         32'h0080_0001, 1'b0, 32'h0},
      '{CMD_HALF,         32'h3f80_0000, 1'b1, 32'h3f00_0000},
      // float to int: NaN, below one, negative zero, overflow both signs
      '{CMD_FLOAT_TO_INT, 32'h7fc0_0000, 1'b1, 32'h0000_0000},
      '{CMD_FLOAT_TO_INT, 32'h3f7f_ffff, 1'b1, 32'h0000_0000},
      '{CMD_FLOAT_TO_INT, 32'h8000_0000, 1'b1, 32'h0000_0000},
      '{CMD_FLOAT_TO_INT, 32'h4f00_0000, 1'b1, 32'h8000_0000},
      '{CMD_FLOAT_TO_INT, 32'hff80_0000, 1'b1, 32'h8000_0000},
      '{CMD_FLOAT_TO_INT, 32'h4eff_ffff, 1'b0, 32'h0},
      '{CMD_FLOAT_TO_INT, 32'hbfc0_0000, 1'b0, 32'h0},
      // int to float: zero, most negative, carry out of rounding, tie
      '{CMD_INT_TO_FLOAT, 32'h0000_0000, 1'b1, 32'h0000_0000},
      '{CMD_INT_TO_FLOAT, 32'h8000_0000, 1'b1, 32'hcf00_0000},
      '{CMD_INT_TO_FLOAT, 32'h7fff_ffff, 1'b0, 32'h0},
      '{CMD_INT_TO_FLOAT, 32'h0100_0001, 1'b0, 32'h0},
      // undefined codes
      '{CMD_UNUSED_6,     32'hffff_ffff, 1'b1, 32'h0000_0000},
      '{CMD_UNUSED_7,     32'h1234_5678, 1'b1, 32'h0000_0000}
   };

   // Expected result of one operation on a binary32 pattern.
   function automatic logic [WORD_W-1:0] predict_bit_op(input logic [CMD_W-1:0] op,
                                                         input logic [WORD_W-1:0] w);
      logic              s;
      logic [EXP_W-1:0]  e;
      logic [22:0]       m;
      logic [30:0]       mag;
      logic              nan;
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] v;
      logic [WORD_W-1:0] keep;
      logic [WORD_W-1:0] rem;
      logic [WORD_W-1:0] tie;
      logic [EXP_W-1:0]  ie;
      logic [WORD_W-1:0] r;
      int                p;
      int                sh;
      s   = w[31];
      e   = w[30:23];
      m   = w[22:0];
      mag = w[30:0];
      nan = (e == EXP_MAX) && (m != '0);
      r   = '0;
      case (op)
         CMD_NEGATE: begin
            r = nan ? w : (w ^ SIGN_BIT);
         end
         CMD_ABSOLUTE: begin
            r = nan ? w : (w & MAG_MASK);
         end
         CMD_TWICE: begin
            if (e == EXP_MAX) r = w;
            else if (e == '0) r = {s, 31'b0} | ({9'b0, m} << 1);
            else if (e == EXP_MAX - 8'd1) r = {s, EXP_MAX, 23'b0};
            else r = {s, e + 8'd1, m};
         end
         CMD_HALF: begin
            if (e == EXP_MAX) r = w;
            else if (e <= 8'd1) r = {s, (mag >> 1) + {30'b0, mag[1:0] == 2'b11}};
            else r = {s, mag - 31'h80_0000};
         end
         CMD_FLOAT_TO_INT: begin
            if (nan || e < EXP_BIAS) r = '0;
            else if (e >= F2I_OVF_EXP) r = SIGN_BIT;
            else begin
               sh = int'(e) - int'(EXP_BIAS);
               a  = {8'b0, 1'b1, m};
               v  = (sh > 23) ? (a << (sh - 23)) : (a >> (23 - sh));
               r  = s ? -v : v;
            end
         end
         CMD_INT_TO_FLOAT: begin
            a = s ? -w : w;
            if (a != '0) begin
               p = 31;
               while (!a[p]) p--;
               ie = 8'(p) + EXP_BIAS;
               if (p > 23) begin
                  sh   = p - 23;
                  rem  = a & ((32'd1 << sh) - 32'd1);
                  tie  = 32'd1 << (sh - 1);
                  keep = a >> sh;
                  if (rem > tie || (rem == tie && keep[0])) keep = keep + 32'd1;
                  if (keep[24]) begin
                     keep = keep >> 1;
                     ie   = ie + 8'd1;
                  end
               end else begin
                  keep = a << (23 - p);
               end
               r = {s, ie, keep[22:0]};
            end
         end
         default: begin
            r = '0;
         end
      endcase
      return r;
   endfunction

   pending_word_type expected_words [$];
   pending_word_type want;
   int               mismatch_count = 0;
   int               cycle_count = 0;
   int               sender_idle_pct = 0;
   int               receiver_stall_pct = 0;
   // Typed expectation that rides along with the current payload.
   logic              row_has_word = 1'b0;
   logic [WORD_W-1:0] row_word = '0;

   task automatic report_mismatch(input string what, input pending_word_type item,
                                  input logic [WORD_W-1:0] got);
      $display("MISMATCH %s: cmd %0d operand %h expected %h got %h",
               what, item.op, item.operand, item.word, got);
      mismatch_count++;
   endtask

   // Drive one transfer at the falling edge, with random idle cycles ahead of
   // it, then hold the payload until an edge with no stall takes it.
   task automatic send_transfer(input logic [CMD_W-1:0] op, input logic [WORD_W-1:0] operand,
                                input logic has_word, input logic [WORD_W-1:0] word);
      @(negedge clock);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_cmd      <= op;
      req_operand  <= operand;
      row_has_word <= has_word;
      row_word     <= word;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_results_drained();
      while (expected_words.size() != 0) @(posedge clock);
   endtask

   // Receiver back-pressure, redrawn every falling edge.
   always @(negedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
   end

   // Scoreboard: retire the result transfer first, then log the request
   // transfer of the same edge. A result never belongs to a request taken
   // on the same edge, since the block registers its input.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               report_mismatch("unexpected result", '0, rsp_result);
            end else begin
               want = expected_words.pop_front();
               if (rsp_result !== want.word) report_mismatch("result", want, rsp_result);
            end
         end
         if (req_valid && !req_stall) begin
            expected_words.push_back('{req_cmd, req_operand,
               row_has_word ? row_word : predict_bit_op(req_cmd, req_operand)});
         end
      end
   end

   // Watchdog: a hang or a lost result ends up here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      logic [CMD_W-1:0]  op;
      logic [WORD_W-1:0] operand;
      logic [WORD_W-1:0] mag;
      logic              sign;
      logic [EXP_W-1:0]  exp_f;
      logic [22:0]       frac;
      int                phase;
      int                n;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (phase = 0; phase < N_PHASES; phase++) begin
         // no idling, sender idle, receiver stalling, then both at a lower rate
         case (phase)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 73; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 73; end
            default: begin sender_idle_pct = 17; receiver_stall_pct = 17; end
         endcase

         if (phase == 0) begin
            foreach (directed_rows[i])
               send_transfer(directed_rows[i].op, directed_rows[i].operand,
                             directed_rows[i].has_word, directed_rows[i].word);
         end

         for (n = 0; n < RANDOM_PER_PHASE; n++) begin
            op = ($urandom_range(0, 99) < 3) ? 3'($urandom_range(6, 7))
                                             : 3'($urandom_range(0, 5));
            sign = 1'($urandom_range(0, 1));
            // bias exponents toward the edges where the operations branch
            case ($urandom_range(0, 7))
               0: exp_f = 8'h00;
               1: exp_f = 8'h01;
               2: exp_f = 8'hfe;
               3: exp_f = EXP_MAX;
               4: exp_f = 8'($urandom_range(8'h7d, 8'h9f));
               5: exp_f = F2I_OVF_EXP;
               default: exp_f = 8'($urandom());
            endcase
            case ($urandom_range(0, 3))
               0: frac = '0;
               1: frac = '1;
               2: frac = 23'($urandom_range(0, 3));
               default: frac = 23'($urandom());
            endcase
            operand = {sign, exp_f, frac};
            if (op == CMD_INT_TO_FLOAT && $urandom_range(0, 1) == 1) begin
               // integers of every magnitude, and exact ties at 31 bits
               if ($urandom_range(0, 3) == 0)
                  mag = ($urandom() & 32'h3fff_ff80) | 32'h4000_0040;
               else
                  mag = $urandom() >> $urandom_range(0, 31);
               operand = sign ? -mag : mag;
            end
            send_transfer(op, operand, 1'b0, '0);
         end

         // hold off the sender until the block has returned everything
         @(negedge clock);
         req_valid <= 1'b0;
         wait_results_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_words.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire
